// ----- sv/wbt_pkg.sv -----
// ----------------------------------------------------------------------------
// wbt_pkg
// Shared types and constants for the waveform block transfer sender.
// ----------------------------------------------------------------------------
package wbt_pkg;

  localparam int unsigned PAYLOAD_BYTES = 1024;
  localparam int unsigned DVD_W         = 41;  // ring start plus block byte offset
  localparam int unsigned CNT_W         = 6;   // holds DVD_W

  localparam logic [2:0] REG_ACQ_WORDS   = 3'd0;
  localparam logic [2:0] REG_BYTES_WORD  = 3'd1;
  localparam logic [2:0] REG_RING_BYTES  = 3'd2;
  localparam logic [2:0] REG_ACK_MAGIC   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_US  = 3'd4;
  localparam logic [2:0] REG_RETRY_LIMIT = 3'd5;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_FULL = 2'd1,
    OP_ACK  = 2'd2,
    OP_TICK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_ACTIVE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    MSEL_SPAN = 2'd0,
    MSEL_WOFS = 2'd1,
    MSEL_OFF  = 2'd2
  } msel_e;

  typedef struct packed {
    logic  load_in;
    logic  arm_apply;
    logic  mod_start;
    msel_e mod_sel;
    logic  save_span;
    logic  full_capture;
    logic  ack_advance;
    logic  retry_inc;
    logic  go_idle;
    logic  idle_clear;
    logic  save_off;
    logic  emit_header;
    logic  emit_data;
  } cmd_t;

  typedef struct packed {
    op_e    op;
    phase_e phase;
    logic   ack_match;
    logic   timed_out;
    logic   retry_ok;
    logic   rem_zero;
    logic   mod_done;
    logic   slot_free;
  } stat_t;

endpackage

// ----- sv/wbt_if.sv -----
// ----------------------------------------------------------------------------
// wbt_in_if / wbt_out_if
// Valid/ready channels carrying event requests and packet descriptors.
// ----------------------------------------------------------------------------
interface wbt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] now_us;
  logic        arm_request;
  logic        recorder_armed;
  logic [26:0] captured_words;
  logic [29:0] write_offset;
  logic [31:0] stamp_sec;
  logic [31:0] stamp_frac;
  logic [31:0] in_magic;
  logic [31:0] in_waveform;
  logic [25:0] in_block;

  modport source (output valid, operation, now_us, arm_request, recorder_armed,
                  captured_words, write_offset, stamp_sec, stamp_frac, in_magic,
                  in_waveform, in_block, input ready);
  modport sink   (input valid, operation, now_us, arm_request, recorder_armed,
                  captured_words, write_offset, stamp_sec, stamp_frac, in_magic,
                  in_waveform, in_block, output ready);
endinterface

interface wbt_out_if;
  logic        valid;
  logic        ready;
  logic        packet_kind;
  logic [31:0] wave_id;
  logic [25:0] block_id;
  logic [30:0] total_bytes;
  logic [31:0] sec_out;
  logic [31:0] frac_out;
  logic [29:0] ring_offset;
  logic [13:0] block_bytes;
  logic [13:0] first_part_bytes;

  modport source (output valid, packet_kind, wave_id, block_id, total_bytes, sec_out,
                  frac_out, ring_offset, block_bytes, first_part_bytes, input ready);
  modport sink   (input valid, packet_kind, wave_id, block_id, total_bytes, sec_out,
                  frac_out, ring_offset, block_bytes, first_part_bytes, output ready);
endinterface

// ----- sv/wbt_mod.sv -----
// ----------------------------------------------------------------------------
// wbt_mod
// Bit-serial restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wbt_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wbt_pkg::DVD_W-1:0]   dividend_i,
  input  logic [30:0]                 divisor_i,
  output logic                        done_o,
  output logic [30:0]                 rem_o
);
  import wbt_pkg::*;

  logic [DVD_W-1:0] dvd_q;
  logic [30:0]      d_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [31:0]      sh;
  logic [31:0]      diff;

  assign sh   = {rem_q, dvd_q[DVD_W-1]};
  assign diff = sh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      d_q   <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q <= (sh >= {1'b0, d_q}) ? diff[30:0] : sh[30:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = (d_q == '0) ? '0 : rem_q;
endmodule

// ----- sv/wbt_datapath.sv -----
// ----------------------------------------------------------------------------
// wbt_datapath
// Registers, transfer state, offset arithmetic and the packet output stage.
// ----------------------------------------------------------------------------
module wbt_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  wbt_pkg::cmd_t   cmd_i,
  output wbt_pkg::stat_t  stat_o,
  wbt_in_if.sink          in_i,
  wbt_out_if.source       out_o
);
  import wbt_pkg::*;

  // configuration
  logic [26:0] acq_q;
  logic [6:0]  bpw_q;
  logic [30:0] ring_q;
  logic [31:0] magic_q, timeout_q;
  logic [7:0]  limit_q;

  // latched request
  op_e         op_q;
  logic [31:0] now_q, sec_in_q, frac_in_q, mag_q, wav_q;
  logic        arm_q, armed_q;
  logic [26:0] cnt_q;
  logic [29:0] wofs_q;
  logic [25:0] blk_q;

  // transfer state
  phase_e      phase_q;
  logic [31:0] wave_q, send_q, hsec_q, hfrac_q;
  logic [25:0] block_q;
  logic [29:0] start_q;
  logic [30:0] remain_q, hbytes_q, span_q, off_q;
  logic [13:0] lastb_q;
  logic [7:0]  tally_q;

  // output stage
  logic        valid_q, kind_q;
  logic [31:0] wid_q, osec_q, ofrac_q;
  logic [25:0] bid_q;
  logic [30:0] tot_q;
  logic [29:0] roff_q;
  logic [13:0] len_q, first_q;

  logic             mod_done;
  logic [30:0]      mod_rem;
  logic [DVD_W-1:0] dividend;
  logic [26:0]      cnt_clamp;
  logic [33:0]      total;
  logic [31:0]      start_sum, start_red;
  logic [13:0]      len;
  logic [13:0]      first;
  logic [31:0]      elapsed;

  always_comb begin
    unique case (cmd_i.mod_sel)
      MSEL_SPAN: dividend = DVD_W'(34'(acq_q) * 34'(bpw_q));
      MSEL_WOFS: dividend = DVD_W'(wofs_q);
      MSEL_OFF:  dividend = DVD_W'(start_q) + DVD_W'(block_q) * DVD_W'(PAYLOAD_BYTES);
      default:   dividend = '0;
    endcase
  end

  wbt_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (dividend),
    .divisor_i  (ring_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign cnt_clamp = (cnt_q > acq_q) ? acq_q : cnt_q;
  assign total     = 34'(cnt_clamp) * 34'(bpw_q);
  assign start_sum = 32'(mod_rem) + 32'(ring_q) - 32'(span_q);
  assign start_red = (start_sum >= 32'(ring_q)) ? start_sum - 32'(ring_q) : start_sum;
  assign len       = (remain_q > 31'(PAYLOAD_BYTES)) ? 14'(PAYLOAD_BYTES) : remain_q[13:0];
  assign first     = (ring_q == '0 || 32'(off_q) + 32'(len) <= 32'(ring_q))
                     ? len : 14'(ring_q - off_q);
  assign elapsed   = now_q - send_q;

  assign stat_o.op        = op_q;
  assign stat_o.phase     = phase_q;
  assign stat_o.ack_match = (mag_q == magic_q) && (wav_q == wave_q) && (blk_q == block_q);
  assign stat_o.timed_out = elapsed > timeout_q;
  assign stat_o.retry_ok  = tally_q < limit_q;
  assign stat_o.rem_zero  = remain_q == '0;
  assign stat_o.mod_done  = mod_done;
  assign stat_o.slot_free = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acq_q     <= 27'd10000;
      bpw_q     <= 7'd16;
      ring_q    <= 31'd1048576;
      magic_q   <= '0;
      timeout_q <= 32'd1000000;
      limit_q   <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACQ_WORDS:   acq_q     <= cfg_data_i[26:0];
        REG_BYTES_WORD:  bpw_q     <= cfg_data_i[6:0];
        REG_RING_BYTES:  ring_q    <= cfg_data_i[30:0];
        REG_ACK_MAGIC:   magic_q   <= cfg_data_i;
        REG_TIMEOUT_US:  timeout_q <= cfg_data_i;
        REG_RETRY_LIMIT: limit_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= op_e'(in_i.operation);
      now_q     <= in_i.now_us;
      arm_q     <= in_i.arm_request;
      armed_q   <= in_i.recorder_armed;
      cnt_q     <= in_i.captured_words;
      wofs_q    <= in_i.write_offset;
      sec_in_q  <= in_i.stamp_sec;
      frac_in_q <= in_i.stamp_frac;
      mag_q     <= in_i.in_magic;
      wav_q     <= in_i.in_waveform;
      blk_q     <= in_i.in_block;
    end
    if (cmd_i.save_span) span_q <= mod_rem;
    if (cmd_i.save_off)  off_q  <= mod_rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      wave_q   <= 32'd1;
      block_q  <= '0;
      start_q  <= '0;
      remain_q <= '0;
      lastb_q  <= '0;
      send_q   <= '0;
      tally_q  <= '0;
      hbytes_q <= '0;
      hsec_q   <= '0;
      hfrac_q  <= '0;
    end else begin
      if (cmd_i.arm_apply && arm_q) begin
        if (!armed_q) wave_q <= wave_q + 32'd1;
        phase_q <= PH_IDLE;
      end
      if (cmd_i.full_capture) begin
        hbytes_q <= (total > 34'h7FFF_FFFF) ? 31'h7FFF_FFFF : total[30:0];
        start_q  <= start_red[29:0];
        hsec_q   <= sec_in_q;
        hfrac_q  <= frac_in_q;
        tally_q  <= '0;
      end
      if (cmd_i.ack_advance) begin
        tally_q <= '0;
        if (phase_q == PH_ACTIVE) begin
          block_q  <= block_q + 26'd1;
          remain_q <= (31'(lastb_q) < remain_q) ? remain_q - 31'(lastb_q) : '0;
        end
      end
      if (cmd_i.retry_inc) tally_q <= tally_q + 8'd1;
      if (cmd_i.go_idle)   phase_q <= PH_IDLE;
      if (cmd_i.idle_clear) begin
        phase_q <= PH_IDLE;
        lastb_q <= '0;
      end
      if (cmd_i.emit_header) begin
        block_q  <= '0;
        lastb_q  <= '0;
        remain_q <= hbytes_q;
        send_q   <= now_q;
        phase_q  <= PH_HEADER;
      end
      if (cmd_i.emit_data) begin
        phase_q <= PH_ACTIVE;
        lastb_q <= len;
        send_q  <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit_header || cmd_i.emit_data) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_header) begin
      kind_q  <= 1'b0;
      wid_q   <= wave_q;
      bid_q   <= '0;
      tot_q   <= hbytes_q;
      osec_q  <= hsec_q;
      ofrac_q <= hfrac_q;
      roff_q  <= '0;
      len_q   <= '0;
      first_q <= '0;
    end else if (cmd_i.emit_data) begin
      kind_q  <= 1'b1;
      wid_q   <= wave_q;
      bid_q   <= block_q;
      tot_q   <= '0;
      osec_q  <= '0;
      ofrac_q <= '0;
      roff_q  <= off_q[29:0];
      len_q   <= len;
      first_q <= first;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.packet_kind      = kind_q;
  assign out_o.wave_id          = wid_q;
  assign out_o.block_id         = bid_q;
  assign out_o.total_bytes      = tot_q;
  assign out_o.sec_out          = osec_q;
  assign out_o.frac_out         = ofrac_q;
  assign out_o.ring_offset      = roff_q;
  assign out_o.block_bytes      = len_q;
  assign out_o.first_part_bytes = first_q;
endmodule

// ----- sv/wbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// wbt_ctrl
// Sequencer: decodes each request and steps the datapath through it.
// ----------------------------------------------------------------------------
module wbt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  wbt_pkg::stat_t  stat_i,
  output wbt_pkg::cmd_t   cmd_o
);
  import wbt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_ADV, S_MOD_SPAN, S_MOD_WOFS, S_MOD_OFF, S_EMIT_HDR, S_EMIT_DATA
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        unique case (stat_i.op)
          OP_ARM: cmd_o.arm_apply = 1'b1;
          OP_FULL: begin
            if (stat_i.phase == PH_IDLE) begin
              cmd_o.mod_start = 1'b1;
              cmd_o.mod_sel   = MSEL_SPAN;
              state_d = S_MOD_SPAN;
            end
          end
          OP_ACK: begin
            if (stat_i.phase != PH_IDLE && stat_i.ack_match) begin
              cmd_o.ack_advance = 1'b1;
              state_d = S_ADV;
            end
          end
          OP_TICK: begin
            if (stat_i.phase != PH_IDLE && stat_i.timed_out) begin
              cmd_o.retry_inc = 1'b1;
              state_d = S_ADV;
            end
          end
          default: ;
        endcase
      end
      S_ADV: begin
        // retry_ok is only meaningful after a tick bumped the tally
        priority if (stat_i.op == OP_TICK && !stat_i.retry_ok) begin
          cmd_o.go_idle = 1'b1;
          state_d = S_IDLE;
        end else if (stat_i.op == OP_TICK && stat_i.phase == PH_HEADER) begin
          state_d = S_EMIT_HDR;
        end else if (stat_i.rem_zero) begin
          cmd_o.idle_clear = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.mod_start = 1'b1;
          cmd_o.mod_sel   = MSEL_OFF;
          state_d = S_MOD_OFF;
        end
      end
      S_MOD_SPAN: begin
        if (stat_i.mod_done) begin
          cmd_o.save_span = 1'b1;
          cmd_o.mod_start = 1'b1;
          cmd_o.mod_sel   = MSEL_WOFS;
          state_d = S_MOD_WOFS;
        end
      end
      S_MOD_WOFS: begin
        if (stat_i.mod_done) begin
          cmd_o.full_capture = 1'b1;
          state_d = S_EMIT_HDR;
        end
      end
      S_MOD_OFF: begin
        cmd_o.mod_sel = MSEL_OFF;
        if (stat_i.mod_done) begin
          cmd_o.save_off = 1'b1;
          state_d = S_EMIT_DATA;
        end
      end
      S_EMIT_HDR: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_header = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT_DATA: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_data = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ----- sv/waveform_block_transfer.sv -----
// Arm and ignored requests retire straight from the decode state, and requests
// that exhaust the retry limit from the advance state; a data packet waits for
// one remainder from the bit-serial ring modulo unit (41 dividend bits) and a
// header from a full request for two.
// Throughput: one request at a time; the next is taken as soon as the packet
// is parked in the output register. Reset clears the protocol state, loads
// register defaults and needs no clearing pass.
// ----------------------------------------------------------------------------
// waveform_block_transfer
// Stop-and-wait sender of header and data block descriptors for a ring capture.
// ----------------------------------------------------------------------------
module waveform_block_transfer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  wbt_in_if.sink      in_i,
  wbt_out_if.source   out_o
);
  import wbt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: takes one request, walks it through modulo and emit steps.
  wbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: config, transfer state, ring arithmetic, output register.
  wbt_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_i       (in_i),
    .out_o      (out_o)
  );
endmodule
